FILE: hw/rtl/gsa_pkg.sv
// Shared types and constants for the generational slot allocator.
// No dependencies; imported by the find-first unit and the top level.
package gsa_pkg;

    // Handle geometry
    localparam int SLOT_COUNT = 1024;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int GEN_W      = 16;
    localparam int CNT_W      = IDX_W + 1;

    // Alive marks are packed into words of WORD_W bits
    localparam int WORD_W  = 32;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int WORDS   = SLOT_COUNT / WORD_W;
    localparam int WADDR_W = IDX_W - BIT_W;

    // Request codes
    localparam logic [1:0] REQ_SPAWN   = 2'd0;
    localparam logic [1:0] REQ_DESPAWN = 2'd1;
    localparam logic [1:0] REQ_CHECK   = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_STALE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Result of the shared find-first unit
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } ff_res_t;

endpackage

FILE: hw/rtl/gsa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/gsa_find_first.sv
// Shared find-first unit: position of the lowest set bit of one word.
// Depends on gsa_pkg for the word width and result type.
module gsa_find_first
    import gsa_pkg::*;
(
    input  logic [WORD_W-1:0] vec,
    output ff_res_t           res
);

    // Priority encoder, lowest bit wins
    always_comb begin
        res.found = |vec;
        res.pos   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (vec[i]) begin
                res.pos = BIT_W'(i);
            end
        end
    end

endmodule

FILE: hw/rtl/generational_slot_allocator_top.sv
// Generational slot allocator, top level: sequencer, counters and storage.
// Depends on gsa_pkg, gsa_ram and gsa_find_first.
//
// One request is worked at a time. A spawn that reuses a freed slot steps
// through FSM_SPWORD, FSM_SPGEN and FSM_OUT; a spawn of a never-used slot
// through FSM_NEWW and FSM_OUT; a despawn and a check through FSM_CHK and
// FSM_OUT; a spawn with no slot left and an unknown request type go straight
// to FSM_OUT, which loads the result word onto the output. While an earlier
// result word waits on a stalled output, the block holds in FSM_OUT. These
// steps are set by the registered reads of the two RAMs (alive-mark words and
// generations): the lowest free slot is found by one shared find-first unit
// used first on a per-word free summary register, then on the alive word read
// back from RAM. Entries at or above the count of ever-issued slots are never
// trusted, so no clearing pass is needed after reset. The block takes a new
// request while an earlier result word still waits on the output.
module generational_slot_allocator_top
    import gsa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_req_type,
    input  logic [IDX_W-1:0] s_slot_index,
    input  logic [GEN_W-1:0] s_handle_gen,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [IDX_W-1:0] m_out_index,
    output logic [GEN_W-1:0] m_out_gen,
    output logic             m_is_live,
    output logic [CNT_W-1:0] m_live_total
);

    // Sequencer states
    localparam logic [2:0] FSM_IDLE   = 3'd0;
    localparam logic [2:0] FSM_SPWORD = 3'd1;
    localparam logic [2:0] FSM_SPGEN  = 3'd2;
    localparam logic [2:0] FSM_NEWW   = 3'd3;
    localparam logic [2:0] FSM_CHK    = 3'd4;
    localparam logic [2:0] FSM_OUT    = 3'd5;

    // Valid-slot mask for one alive word, given the count of issued slots
    function automatic logic [WORD_W-1:0] word_mask(
        input logic [WADDR_W-1:0] w,
        input logic [CNT_W-1:0]   used
    );
        logic [CNT_W-BIT_W-1:0] used_word;
        logic [WORD_W-1:0]      m;
        used_word = used[CNT_W-1:BIT_W];
        if ((CNT_W-BIT_W)'(w) < used_word) begin
            m = '1;
        end else if ((CNT_W-BIT_W)'(w) == used_word) begin
            m = ({{(WORD_W-1){1'b0}}, 1'b1} << used[BIT_W-1:0]) - 1'b1;
        end else begin
            m = '0;
        end
        return m;
    endfunction

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   live_reg, live_next;
    logic [WORDS-1:0]   summ_reg, summ_next;

    logic [1:0]         req_reg, req_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [GEN_W-1:0]   hgen_reg, hgen_next;
    logic [WADDR_W-1:0] wsel_reg, wsel_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;

    logic [1:0]         res_stat_reg, res_stat_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic [GEN_W-1:0]   res_gen_reg, res_gen_next;
    logic               res_live_reg, res_live_next;

    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [IDX_W-1:0]   m_index_reg, m_index_next;
    logic [GEN_W-1:0]   m_gen_reg, m_gen_next;
    logic               m_live_reg, m_live_next;
    logic [CNT_W-1:0]   m_total_reg, m_total_next;

    // RAM ports
    logic               aw_we;
    logic [WADDR_W-1:0] aw_waddr, aw_raddr;
    logic [WORD_W-1:0]  aw_wdata, aw_rdata;
    logic               gw_we;
    logic [IDX_W-1:0]   gw_waddr, gw_raddr;
    logic [GEN_W-1:0]   gw_wdata, gw_rdata;

    // Shared find-first unit
    logic [WORD_W-1:0]  ff_vec;
    ff_res_t            ff_res;

    // Datapath helpers
    logic [WORD_W-1:0]  free_bits;
    logic [WORD_W-1:0]  pick_hot;
    logic [WORD_W-1:0]  own_hot;
    logic               hit;
    logic [GEN_W-1:0]   gen_bump;

    gsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_alive_ram (
        .aclk  (aclk),
        .we    (aw_we),
        .waddr (aw_waddr),
        .wdata (aw_wdata),
        .raddr (aw_raddr),
        .rdata (aw_rdata)
    );

    gsa_ram #(
        .WIDTH (GEN_W),
        .DEPTH (SLOT_COUNT)
    ) u_gen_ram (
        .aclk  (aclk),
        .we    (gw_we),
        .waddr (gw_waddr),
        .wdata (gw_wdata),
        .raddr (gw_raddr),
        .rdata (gw_rdata)
    );

    gsa_find_first u_ff (
        .vec (ff_vec),
        .res (ff_res)
    );

    // Free slots in the word just read, and per-request bit decodes
    assign free_bits = ~aw_rdata & word_mask(wsel_reg, used_reg);
    assign pick_hot  = {{(WORD_W-1){1'b0}}, 1'b1} << ff_res.pos;
    assign own_hot   = {{(WORD_W-1){1'b0}}, 1'b1} << idx_reg[BIT_W-1:0];
    assign hit       = ((CNT_W)'(idx_reg) < used_reg) && aw_rdata[idx_reg[BIT_W-1:0]]
                       && (gw_rdata == hgen_reg);
    assign gen_bump  = (gw_rdata == {GEN_W{1'b1}}) ? GEN_W'(1) : gw_rdata + 1'b1;

    // Find-first operand: summary on acceptance, free bits of the word later
    always_comb begin
        if (state_reg == FSM_SPWORD) begin
            ff_vec = free_bits;
        end else begin
            ff_vec = WORD_W'(summ_reg);
        end
    end

    assign s_ready = (state_reg == FSM_IDLE);

    // Sequencer and datapath control
    always_comb begin
        state_next    = state_reg;
        used_next     = used_reg;
        live_next     = live_reg;
        summ_next     = summ_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        hgen_next     = hgen_reg;
        wsel_next     = wsel_reg;
        slot_next     = slot_reg;
        res_stat_next = res_stat_reg;
        res_idx_next  = res_idx_reg;
        res_gen_next  = res_gen_reg;
        res_live_next = res_live_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_index_next  = m_index_reg;
        m_gen_next    = m_gen_reg;
        m_live_next   = m_live_reg;
        m_total_next  = m_total_reg;

        aw_we    = 1'b0;
        aw_waddr = wsel_reg;
        aw_wdata = aw_rdata;
        aw_raddr = s_slot_index[IDX_W-1:BIT_W];
        gw_we    = 1'b0;
        gw_waddr = idx_reg;
        gw_wdata = gen_bump;
        gw_raddr = s_slot_index;

        unique case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    req_next      = s_req_type;
                    idx_next      = s_slot_index;
                    hgen_next     = s_handle_gen;
                    res_stat_next = STAT_OK;
                    res_idx_next  = '0;
                    res_gen_next  = '0;
                    res_live_next = 1'b0;
                    priority if (s_req_type == REQ_SPAWN) begin
                        if (ff_res.found) begin
                            // Reuse the lowest freed slot
                            aw_raddr   = WADDR_W'(ff_res.pos);
                            wsel_next  = WADDR_W'(ff_res.pos);
                            state_next = FSM_SPWORD;
                        end else if (used_reg < CNT_W'(SLOT_COUNT)) begin
                            // Fresh slot at the top of the issued range
                            aw_raddr   = used_reg[IDX_W-1:BIT_W];
                            wsel_next  = used_reg[IDX_W-1:BIT_W];
                            state_next = FSM_NEWW;
                        end else begin
                            res_stat_next = STAT_FULL;
                            state_next    = FSM_OUT;
                        end
                    end else if (s_req_type == REQ_DESPAWN || s_req_type == REQ_CHECK) begin
                        wsel_next  = s_slot_index[IDX_W-1:BIT_W];
                        state_next = FSM_CHK;
                    end else begin
                        state_next = FSM_OUT;
                    end
                end
            end
            FSM_SPWORD: begin
                // Mark the chosen slot alive, fetch its generation
                slot_next           = {wsel_reg, ff_res.pos};
                aw_we               = 1'b1;
                aw_wdata            = aw_rdata | pick_hot;
                gw_raddr            = {wsel_reg, ff_res.pos};
                summ_next[wsel_reg] = |(free_bits & ~pick_hot);
                live_next           = live_reg + 1'b1;
                state_next          = FSM_SPGEN;
            end
            FSM_SPGEN: begin
                res_idx_next = slot_reg;
                res_gen_next = gw_rdata;
                state_next   = FSM_OUT;
            end
            FSM_NEWW: begin
                aw_we        = 1'b1;
                aw_wdata     = aw_rdata
                               | ({{(WORD_W-1){1'b0}}, 1'b1} << used_reg[BIT_W-1:0]);
                gw_we        = 1'b1;
                gw_waddr     = used_reg[IDX_W-1:0];
                gw_wdata     = GEN_W'(1);
                res_idx_next = used_reg[IDX_W-1:0];
                res_gen_next = GEN_W'(1);
                used_next    = used_reg + 1'b1;
                live_next    = live_reg + 1'b1;
                state_next   = FSM_OUT;
            end
            FSM_CHK: begin
                if (req_reg == REQ_DESPAWN) begin
                    if (hit) begin
                        // Retire the slot: clear mark, advance generation
                        aw_we               = 1'b1;
                        aw_wdata            = aw_rdata & ~own_hot;
                        gw_we               = 1'b1;
                        summ_next[wsel_reg] = 1'b1;
                        if (live_reg != '0) begin
                            live_next = live_reg - 1'b1;
                        end
                    end else begin
                        res_stat_next = STAT_STALE;
                    end
                end else begin
                    res_live_next = hit;
                end
                state_next = FSM_OUT;
            end
            FSM_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_stat_reg;
                    m_index_next  = res_idx_reg;
                    m_gen_next    = res_gen_reg;
                    m_live_next   = res_live_reg;
                    m_total_next  = live_reg;
                    state_next    = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            used_reg    <= '0;
            live_reg    <= '0;
            summ_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            live_reg    <= live_next;
            summ_reg    <= summ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        idx_reg      <= idx_next;
        hgen_reg     <= hgen_next;
        wsel_reg     <= wsel_next;
        slot_reg     <= slot_next;
        res_stat_reg <= res_stat_next;
        res_idx_reg  <= res_idx_next;
        res_gen_reg  <= res_gen_next;
        res_live_reg <= res_live_next;
        m_status_reg <= m_status_next;
        m_index_reg  <= m_index_next;
        m_gen_reg    <= m_gen_next;
        m_live_reg   <= m_live_next;
        m_total_reg  <= m_total_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_out_index  = m_index_reg;
    assign m_out_gen    = m_gen_reg;
    assign m_is_live    = m_live_reg;
    assign m_live_total = m_total_reg;

endmodule
